// ===== rtl/websocket_frame_deframer_macros.svh =====
// Assertion helpers for the deframer RTL
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Clocked check, off while reset is asserted
`define WSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define WSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/wsd_pkg.sv =====
`default_nettype none

package wsd_pkg;

    localparam int PHASE_W = 3;
    localparam int CNT_W   = 3;
    localparam int REM_W   = 64;
    localparam int KEY_W   = 32;

    localparam logic [PHASE_W-1:0] PH_HDR0 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR1 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXT  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_KEY  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd4;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [CNT_W-1:0] EXT16_CNT = 3'd1;
    localparam logic [CNT_W-1:0] EXT64_CNT = 3'd7;
    localparam logic [CNT_W-1:0] KEY_CNT   = 3'd3;

    localparam logic [7:0] HDR_RESET = 8'h81;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_end;
        logic       fin_flag;
        logic [3:0] frame_opcode;
        logic [2:0] reserved_bits;
        logic       was_masked;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/wsd_in_if.sv =====
`default_nettype none

interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/wsd_out_if.sv =====
`default_nettype none

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_end;
    logic       fin_flag;
    logic [3:0] frame_opcode;
    logic [2:0] reserved_bits;
    logic       was_masked;

    modport source (
        output valid, output payload_byte, output payload_valid, output frame_end,
        output fin_flag, output frame_opcode, output reserved_bits, output was_masked,
        input ready
    );
    modport sink (
        input valid, input payload_byte, input payload_valid, input frame_end,
        input fin_flag, input frame_opcode, input reserved_bits, input was_masked,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/wsd_in_stage.sv =====
`default_nettype none

module wsd_in_stage (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wsd_in_if.sink     ingress,
    input  wire logic  advance,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign ingress.ready = !valid_reg || advance;
    assign take          = ingress.valid && ingress.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= ingress.in_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

`default_nettype wire

// ===== rtl/wsd_parser.sv =====
`default_nettype none

`include "websocket_frame_deframer_macros.svh"

module wsd_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   byte_data,
    output logic              res_valid,
    output wsd_pkg::result_t  res
);

    logic [wsd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [wsd_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [wsd_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [wsd_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [1:0]                  kidx_reg, kidx_next;
    logic [7:0]                  hdr_reg, hdr_next;
    logic                        mask_reg, mask_next;

    logic                        len_done;
    logic [wsd_pkg::REM_W-1:0]   len_val;
    logic                        emit;
    logic [7:0]                  out_data;
    logic                        out_pv;
    logic                        out_end;
    logic [6:0]                  len7;
    logic [wsd_pkg::REM_W-1:0]   rem_shift;
    logic [7:0]                  key_byte;

    assign len7      = byte_data[6:0];
    assign rem_shift = {rem_reg[wsd_pkg::REM_W-9:0], byte_data};

    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        key_next   = key_reg;
        kidx_next  = kidx_reg;
        hdr_next   = hdr_reg;
        mask_next  = mask_reg;
        len_done   = 1'b0;
        len_val    = rem_reg;
        emit       = 1'b0;
        out_data   = 8'd0;
        out_pv     = 1'b0;
        out_end    = 1'b0;

        case (phase_reg)
            wsd_pkg::PH_HDR1:
            begin
                mask_next = byte_data[7];
                if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64)
                begin
                    rem_next   = '0;
                    cnt_next   = (len7 == wsd_pkg::LEN_EXT16) ? wsd_pkg::EXT16_CNT
                                                              : wsd_pkg::EXT64_CNT;
                    phase_next = wsd_pkg::PH_EXT;
                end
                else
                begin
                    len_val  = {{(wsd_pkg::REM_W-7){1'b0}}, len7};
                    rem_next = len_val;
                    len_done = 1'b1;
                end
            end
            wsd_pkg::PH_EXT:
            begin
                rem_next = rem_shift;
                len_val  = rem_shift;
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    len_done = 1'b1;
                end
            end
            wsd_pkg::PH_KEY:
            begin
                key_next = {key_reg[wsd_pkg::KEY_W-9:0], byte_data};
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    kidx_next = 2'd0;
                    if (rem_reg == '0)
                    begin
                        phase_next = wsd_pkg::PH_HDR0;
                        emit       = 1'b1;
                        out_end    = 1'b1;
                    end
                    else
                    begin
                        phase_next = wsd_pkg::PH_DATA;
                    end
                end
            end
            wsd_pkg::PH_DATA:
            begin
                out_data  = mask_reg ? (byte_data ^ key_byte) : byte_data;
                out_pv    = 1'b1;
                out_end   = (rem_reg == {{(wsd_pkg::REM_W-1){1'b0}}, 1'b1});
                emit      = 1'b1;
                kidx_next = kidx_reg + 2'd1;
                rem_next  = rem_reg - 1'b1;
                if (out_end)
                begin
                    phase_next = wsd_pkg::PH_HDR0;
                end
            end
            default:
            begin
                hdr_next   = byte_data;
                mask_next  = 1'b0;
                rem_next   = '0;
                cnt_next   = '0;
                kidx_next  = 2'd0;
                phase_next = wsd_pkg::PH_HDR1;
            end
        endcase

        // length known: go to key, payload, or emit the empty marker
        if (len_done)
        begin
            if (mask_next)
            begin
                phase_next = wsd_pkg::PH_KEY;
                cnt_next   = wsd_pkg::KEY_CNT;
            end
            else
            begin
                kidx_next = 2'd0;
                if (len_val == '0)
                begin
                    phase_next = wsd_pkg::PH_HDR0;
                    emit       = 1'b1;
                    out_end    = 1'b1;
                end
                else
                begin
                    phase_next = wsd_pkg::PH_DATA;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wsd_pkg::PH_HDR0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            key_reg   <= '0;
            kidx_reg  <= 2'd0;
            hdr_reg   <= wsd_pkg::HDR_RESET;
            mask_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            key_reg   <= key_next;
            kidx_reg  <= kidx_next;
            hdr_reg   <= hdr_next;
            mask_reg  <= mask_next;
        end
    end

    assign res_valid         = step && emit;
    assign res.payload_byte  = out_data;
    assign res.payload_valid = out_pv;
    assign res.frame_end     = out_end;
    assign res.fin_flag      = hdr_reg[7];
    assign res.frame_opcode  = hdr_reg[3:0];
    assign res.reserved_bits = hdr_reg[6:4];
    assign res.was_masked    = mask_next;

    `WSD_ASSERT(a_data_nonzero, clk, rst_n,
        phase_reg == wsd_pkg::PH_DATA |-> rem_reg != '0, "payload phase with no bytes left")
    `WSD_ASSERT(a_marker_ends, clk, rst_n,
        res_valid && !res.payload_valid |-> res.frame_end, "empty marker without frame end")
    `WSD_ASSERT(a_end_to_hdr, clk, rst_n,
        res_valid && res.frame_end |=> phase_reg == wsd_pkg::PH_HDR0,
        "frame end not followed by header")
    `WSD_ASSERT(a_data_key0, clk, rst_n,
        $rose(phase_reg == wsd_pkg::PH_DATA) |-> kidx_reg == 2'd0, "payload starts off key byte zero")

endmodule

`default_nettype wire

// ===== rtl/wsd_out_stage.sv =====
`default_nettype none

module wsd_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic              res_valid,
    input  wire wsd_pkg::result_t  res,
    output logic                   can_load,
    wsd_out_if.source              egress
);

    logic             valid_reg;
    logic             valid_next;
    wsd_pkg::result_t res_reg;

    assign can_load = !valid_reg || egress.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
        begin
            valid_next = load && res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign egress.valid         = valid_reg;
    assign egress.payload_byte  = res_reg.payload_byte;
    assign egress.payload_valid = res_reg.payload_valid;
    assign egress.frame_end     = res_reg.frame_end;
    assign egress.fin_flag      = res_reg.fin_flag;
    assign egress.frame_opcode  = res_reg.frame_opcode;
    assign egress.reserved_bits = res_reg.reserved_bits;
    assign egress.was_masked    = res_reg.was_masked;

endmodule

`default_nettype wire

// ===== rtl/websocket_frame_deframer.sv =====
// Channel   Dir  Word
// ingress   in   in_byte: raw frame stream byte
// egress    out  payload_byte, payload_valid, frame_end, header flags, was_masked
//
// One byte per cycle while egress is not stalled; a taken byte passes the input register, then the result register.
// The input register feeds the parser, whose phase and length update is combinational.
// Header, length and key bytes give no word on egress, but the last of them gives the end marker of an empty frame.
// egress.ready low with a word waiting holds the result register and the parser;
// the input register takes a byte only if it is empty, and ingress.ready is low while it is full.
// rst_n clears valid flags and resets parser state asynchronously: parser waits for a first header byte.

`default_nettype none

module websocket_frame_deframer (
    input  wire logic clk,
    input  wire logic rst_n,
    wsd_in_if.sink    ingress,
    wsd_out_if.source egress
);

    logic             byte_valid;
    logic [7:0]       byte_data;
    logic             can_load;
    logic             advance;
    logic             res_valid;
    wsd_pkg::result_t res;

    assign advance = byte_valid && can_load;

    wsd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .ingress    (ingress),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    wsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .byte_data (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    wsd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .can_load  (can_load),
        .egress    (egress)
    );

endmodule

`default_nettype wire
